// ----- sv/bahrg_pkg.sv -----
`default_nettype none
package bahrg_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [CFG_W-1:0] ms_t;

  localparam ms_t MS_MAX = {CFG_W{1'b1}};

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD      = 2'd0,
    REG_RELEASE   = 2'd1,
    REG_BLINK     = 2'd2,
    REG_ARM_FLASH = 2'd3
  } cfg_reg_e;

  localparam ms_t HOLD_RST      = 16'd5000;
  localparam ms_t RELEASE_RST   = 16'd5000;
  localparam ms_t BLINK_RST     = 16'd100;
  localparam ms_t ARM_FLASH_RST = 16'd300;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_FLASH   = 2'd1,
    PH_HOLD    = 2'd2,
    PH_RELEASE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    VERDICT_NONE   = 2'd0,
    VERDICT_BOOT   = 2'd1,
    VERDICT_UPDATE = 2'd2
  } verdict_e;

  typedef struct packed {
    ms_t hold_ms;
    ms_t release_ms;
    ms_t blink_ms;
    ms_t arm_flash_ms;
  } cfg_t;

  typedef struct packed {
    logic mode;
    logic cause_power_on;
    logic button_down;
  } in_item_t;

  typedef struct packed {
    logic     led_lit;
    verdict_e verdict;
    logic     armed_now;
  } out_item_t;

endpackage
`default_nettype wire

// ----- sv/bahrg_chan_if.sv -----
`default_nettype none
interface bahrg_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/bahrg_cfg.sv -----
`default_nettype none
module bahrg_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bahrg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bahrg_pkg::CFG_W-1:0]     cfg_wdata,
  output bahrg_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ms      <= bahrg_pkg::HOLD_RST;
      cfg.release_ms   <= bahrg_pkg::RELEASE_RST;
      cfg.blink_ms     <= bahrg_pkg::BLINK_RST;
      cfg.arm_flash_ms <= bahrg_pkg::ARM_FLASH_RST;
    end else if (cfg_we) begin
      unique case (bahrg_pkg::cfg_reg_e'(cfg_index))
        bahrg_pkg::REG_HOLD:      cfg.hold_ms      <= cfg_wdata;
        bahrg_pkg::REG_RELEASE:   cfg.release_ms   <= cfg_wdata;
        bahrg_pkg::REG_BLINK:     cfg.blink_ms     <= cfg_wdata;
        bahrg_pkg::REG_ARM_FLASH: cfg.arm_flash_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/bahrg_core.sv -----
`default_nettype none
module bahrg_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire bahrg_pkg::in_item_t item,
  input  wire bahrg_pkg::cfg_t     cfg,
  output bahrg_pkg::out_item_t   res
);

  logic              armed, armed_next;
  logic              led, led_next;
  bahrg_pkg::phase_e phase, phase_next;
  bahrg_pkg::ms_t    elapsed, elapsed_next, elapsed_inc;
  bahrg_pkg::ms_t    blink, blink_next, blink_inc;
  bahrg_pkg::verdict_e verdict;

  // Saturating counts
  assign elapsed_inc = (elapsed == bahrg_pkg::MS_MAX) ? elapsed : elapsed + 1'b1;
  assign blink_inc   = (blink == bahrg_pkg::MS_MAX) ? blink : blink + 1'b1;

  always_comb begin
    armed_next   = armed;
    led_next     = led;
    phase_next   = phase;
    elapsed_next = elapsed;
    blink_next   = blink;
    verdict      = bahrg_pkg::VERDICT_NONE;
    if (!item.mode) begin
      // Boot event: drop any running sequence
      elapsed_next = '0;
      blink_next   = '0;
      if (!item.cause_power_on) begin
        led_next   = 1'b0;
        phase_next = bahrg_pkg::PH_IDLE;
        verdict    = bahrg_pkg::VERDICT_BOOT;
      end else if (!item.button_down) begin
        armed_next = 1'b0;
        led_next   = 1'b0;
        phase_next = bahrg_pkg::PH_IDLE;
        verdict    = bahrg_pkg::VERDICT_BOOT;
      end else if (!armed) begin
        armed_next = 1'b1;
        led_next   = 1'b1;
        phase_next = bahrg_pkg::PH_FLASH;
      end else begin
        led_next   = 1'b1;
        phase_next = bahrg_pkg::PH_HOLD;
      end
    end else begin
      unique case (phase)
        bahrg_pkg::PH_FLASH: begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= cfg.arm_flash_ms) begin
            led_next   = 1'b0;
            phase_next = bahrg_pkg::PH_IDLE;
            verdict    = bahrg_pkg::VERDICT_BOOT;
          end
        end
        bahrg_pkg::PH_HOLD: begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= cfg.hold_ms) begin
            phase_next   = bahrg_pkg::PH_RELEASE;
            elapsed_next = '0;
            blink_next   = '0;
          end else if (!item.button_down) begin
            led_next   = 1'b0;
            phase_next = bahrg_pkg::PH_IDLE;
            verdict    = bahrg_pkg::VERDICT_BOOT;
          end
        end
        bahrg_pkg::PH_RELEASE: begin
          elapsed_next = elapsed_inc;
          blink_next   = blink_inc;
          if (blink_inc >= cfg.blink_ms) begin
            blink_next = '0;
            led_next   = !led;
            if (!item.button_down) begin
              led_next   = 1'b0;
              phase_next = bahrg_pkg::PH_IDLE;
              verdict    = bahrg_pkg::VERDICT_UPDATE;
            end else if (elapsed_inc >= cfg.release_ms) begin
              led_next   = 1'b0;
              phase_next = bahrg_pkg::PH_IDLE;
              verdict    = bahrg_pkg::VERDICT_BOOT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed   <= 1'b0;
      led     <= 1'b0;
      phase   <= bahrg_pkg::PH_IDLE;
      elapsed <= '0;
      blink   <= '0;
    end else if (advance) begin
      armed   <= armed_next;
      led     <= led_next;
      phase   <= phase_next;
      elapsed <= elapsed_next;
      blink   <= blink_next;
    end
  end

  assign res.led_lit   = led_next;
  assign res.verdict   = verdict;
  assign res.armed_now = armed_next;

endmodule
`default_nettype wire

// ----- sv/button_arm_hold_release_guard.sv -----
// Channel   Role    Handshake      Payload
// evt       sink    valid/ready    mode, cause_power_on, button_down
// result    source  valid/ready    led_lit, verdict, armed_now
// cfg       write   cfg_we         cfg_index (2 bits), cfg_wdata (16 bits)
//
// Each item is held in the input register, then its result is computed and
// lands in the result register, which drives result.valid and result.data;
// one item per cycle sustained when result.ready stays high.
// Synchronous reset restores the register defaults and clears the valid flags and the guard state.
// A stalled result holds the result register; the input register still
// takes one more item and then evt.ready drops until the result drains.
`default_nettype none
module button_arm_hold_release_guard (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [bahrg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bahrg_pkg::CFG_W-1:0]     cfg_wdata,
  bahrg_chan_if.sink                           evt,
  bahrg_chan_if.source                         result
);

  bahrg_pkg::cfg_t      cfg;
  bahrg_pkg::in_item_t  s1_item;
  bahrg_pkg::out_item_t res;
  bahrg_pkg::out_item_t out_item;
  logic                 s1_valid;
  logic                 out_valid;
  logic                 advance;

  bahrg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Move the staged item into the result register when that register is
  // empty or being drained; the guard state commits on the same edge.
  assign advance   = s1_valid && (!out_valid || result.ready);
  assign evt.ready = !s1_valid || advance;

  bahrg_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (evt.valid && evt.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold unless a new item moves in
  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      s1_item <= evt.data;
    end
    if (advance) begin
      out_item <= res;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_item;

endmodule
`default_nettype wire

// ----- sv/bahrg_chk.sv -----
`default_nettype none
module bahrg_chk (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire bahrg_pkg::out_item_t out_data
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Any final verdict turns the LED off
  a_led_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.verdict != bahrg_pkg::VERDICT_NONE |-> !out_data.led_lit)
    else $error("LED lit with a final verdict");

  // Update mode is only reachable with the flag armed
  a_upd_armed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.verdict == bahrg_pkg::VERDICT_UPDATE |-> out_data.armed_now)
    else $error("update verdict without armed flag");

endmodule

bind button_arm_hold_release_guard bahrg_chk u_bahrg_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);
`default_nettype wire

// ----- tb/button_arm_hold_release_guard_tb.sv -----
`default_nettype none
module button_arm_hold_release_guard_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bahrg_pkg::*;

  // Event kinds carried in the mode field
  localparam logic EVT_BOOT = 1'b0;
  localparam logic EVT_TICK = 1'b1;

  // Random stimulus budget and a cap on printed mismatch lines
  localparam int unsigned RANDOM_ITEMS   = 1400;
  localparam int unsigned PRINT_LIMIT    = 40;
  localparam int unsigned SESSIONS_PER_CFG = 6;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  ms_t                  cfg_wdata;

  bahrg_chan_if #(.item_t(in_item_t))  evt_ch ();
  bahrg_chan_if #(.item_t(out_item_t)) res_ch ();

  button_arm_hold_release_guard dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .evt       (evt_ch),
    .result    (res_ch)
  );

  // Timing registers as the block should hold them, plus the guard state
  cfg_t   timing;
  phase_e guard_phase;
  ms_t    guard_elapsed;
  ms_t    guard_blinks;
  logic   guard_led;
  logic   guard_armed;

  // Outputs predicted for accepted items, oldest first
  out_item_t   expected_outputs[$];
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatch_count;

  // Idle controls: gaps on the event side, stalls on the result side
  bit src_gaps;
  bit sink_stalls;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop: far beyond the slowest legal run with the longest idles
  initial begin
    #6_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic ms_t sat_bump(input ms_t v);
    return (v == MS_MAX) ? v : v + 1'b1;
  endfunction

  // Leave the LED dark and go back to idle with the given verdict
  function automatic verdict_e close_sequence(input verdict_e code);
    guard_led   = 1'b0;
    guard_phase = PH_IDLE;
    return code;
  endfunction

  // Advance the guard by one boot event or tick and return the outputs it shows
  function automatic out_item_t advance_guard(input in_item_t it);
    out_item_t o;
    verdict_e  v;
    v = VERDICT_NONE;
    if (it.mode == EVT_BOOT) begin
      // Any boot drops whatever sequence was running
      guard_elapsed = '0;
      guard_blinks  = '0;
      if (!it.cause_power_on) begin
        v = close_sequence(VERDICT_BOOT);
      end else if (!it.button_down) begin
        guard_armed = 1'b0;
        v = close_sequence(VERDICT_BOOT);
      end else if (!guard_armed) begin
        guard_armed = 1'b1;
        guard_led   = 1'b1;
        guard_phase = PH_FLASH;
      end else begin
        guard_led   = 1'b1;
        guard_phase = PH_HOLD;
      end
    end else begin
      case (guard_phase)
        PH_FLASH: begin
          guard_elapsed = sat_bump(guard_elapsed);
          if (guard_elapsed >= timing.arm_flash_ms) v = close_sequence(VERDICT_BOOT);
        end
        PH_HOLD: begin
          guard_elapsed = sat_bump(guard_elapsed);
          // The tick that completes the hold ignores the button
          if (guard_elapsed >= timing.hold_ms) begin
            guard_phase   = PH_RELEASE;
            guard_elapsed = '0;
            guard_blinks  = '0;
          end else if (!it.button_down) begin
            v = close_sequence(VERDICT_BOOT);
          end
        end
        PH_RELEASE: begin
          guard_elapsed = sat_bump(guard_elapsed);
          guard_blinks  = sat_bump(guard_blinks);
          // Sample the button only on a blink toggle
          if (guard_blinks >= timing.blink_ms) begin
            guard_blinks = '0;
            guard_led    = ~guard_led;
            if (!it.button_down) v = close_sequence(VERDICT_UPDATE);
            else if (guard_elapsed >= timing.release_ms) v = close_sequence(VERDICT_BOOT);
          end
        end
        default: ;
      endcase
    end
    o.led_lit   = guard_led;
    o.verdict   = v;
    o.armed_now = guard_armed;
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // Check results before predicting new items: a result can never belong to an
  // item accepted at the same edge, so this order keeps the queue honest.
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (expected_outputs.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_seen));
      end else begin
        want = expected_outputs.pop_front();
        if (got.led_lit !== want.led_lit)
          report_mismatch($sformatf("result %0d led_lit got %0b want %0b",
                                    results_seen, got.led_lit, want.led_lit));
        if (got.verdict !== want.verdict)
          report_mismatch($sformatf("result %0d verdict got %0d want %0d",
                                    results_seen, got.verdict, want.verdict));
        if (got.armed_now !== want.armed_now)
          report_mismatch($sformatf("result %0d armed_now got %0b want %0b",
                                    results_seen, got.armed_now, want.armed_now));
      end
      results_seen++;
    end
    if (!rst && evt_ch.valid && evt_ch.ready)
      expected_outputs.push_back(advance_guard(evt_ch.data));
  end

  // Mostly short idles, a quarter medium, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Result side: alternate ready runs with stalls while stalls are enabled
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      res_ch.ready <= 1'b1;
      repeat (idle_len()) @(posedge clk);
      if (sink_stalls) begin
        res_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  // Present one item and hold it until the block takes it. Valid stays high
  // into the next item unless a gap is drawn.
  task automatic send_evt(input logic mode, input logic por, input logic btn);
    in_item_t it;
    it.mode           = mode;
    it.cause_power_on = por;
    it.button_down    = btn;
    evt_ch.data  <= it;
    evt_ch.valid <= 1'b1;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    items_sent++;
    if (src_gaps && $urandom_range(0, 2) == 0) begin
      evt_ch.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // Send n ticks at the given button level; flip it now and then when
  // flip_odds is nonzero (one chance in flip_odds per tick).
  task automatic send_ticks(input int unsigned n, input logic btn,
                            input int unsigned flip_odds);
    logic level;
    repeat (n) begin
      level = btn;
      if (flip_odds != 0 && $urandom_range(1, flip_odds) == 1) level = ~level;
      send_evt(EVT_TICK, 1'b0, level);
    end
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline
  // run on idle so the block is truly quiet.
  task automatic settle();
    evt_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_outputs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input ms_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_HOLD:      timing.hold_ms      = value;
      REG_RELEASE:   timing.release_ms   = value;
      REG_BLINK:     timing.blink_ms     = value;
      REG_ARM_FLASH: timing.arm_flash_ms = value;
    endcase
  endtask

  // Write all four timing registers back to back; call only when idle
  task automatic program_timing(input ms_t hold, input ms_t rel, input ms_t blink,
                                input ms_t flash);
    write_reg(REG_HOLD, hold);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_BLINK, blink);
    write_reg(REG_ARM_FLASH, flash);
    cfg_we <= 1'b0;
  endtask

  function automatic int unsigned span(input ms_t v, input int unsigned lim);
    return (v < lim) ? v : lim;
  endfunction

  // Run with the timing left at reset: arm and flash for the full default
  // on-time, then start a hold and let go early.
  task automatic test_default_timing();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    send_evt(EVT_BOOT, 1'b1, 1'b1);
    send_ticks(ARM_FLASH_RST, 1'b1, 2);
    send_ticks(2, 1'b0, 0);
    send_evt(EVT_BOOT, 1'b1, 1'b1);
    send_ticks(40, 1'b1, 0);
    send_ticks(1, 1'b0, 0);
    send_evt(EVT_BOOT, 1'b0, 1'b1);
    settle();
  endtask

  // Walk every branch with tiny timing: hold 3, window 4, blink 2, flash 2
  task automatic test_directed_paths();
    program_timing(16'd3, 16'd4, 16'd2, 16'd2);
    // Idle tick with every field high changes nothing
    send_evt(EVT_TICK, 1'b1, 1'b1);
    // Warm boot keeps the flag and boots normally
    send_evt(EVT_BOOT, 1'b0, 1'b1);
    // Cold boot without the button disarms
    send_evt(EVT_BOOT, 1'b1, 1'b0);
    // Arm, then abandon the flash with another cold boot: now a hold
    send_evt(EVT_BOOT, 1'b1, 1'b1);
    send_evt(EVT_TICK, 1'b0, 1'b0);
    send_evt(EVT_BOOT, 1'b1, 1'b1);
    // Early release during the hold
    send_evt(EVT_TICK, 1'b0, 1'b1);
    send_evt(EVT_TICK, 1'b0, 1'b0);
    // Full hold; the tick that completes it ignores a released button,
    // then the release counts only on a blink toggle
    send_evt(EVT_BOOT, 1'b1, 1'b1);
    send_evt(EVT_TICK, 1'b0, 1'b1);
    send_evt(EVT_TICK, 1'b0, 1'b1);
    send_evt(EVT_TICK, 1'b0, 1'b0);
    send_evt(EVT_TICK, 1'b0, 1'b0);
    send_evt(EVT_TICK, 1'b0, 1'b0);
    // Full hold, keep holding through the window until it times out
    send_evt(EVT_BOOT, 1'b1, 1'b1);
    send_ticks(3, 1'b1, 0);
    send_ticks(4, 1'b1, 0);
    // Idle tick with every field low
    send_evt(EVT_TICK, 1'b0, 1'b0);
    settle();
  endtask

  // Every register but blink at the top of its range: the flash and the hold never
  // complete in a short run, so a cold boot and an early release end them.
  task automatic test_full_scale_hold();
    program_timing(MS_MAX, MS_MAX, 16'd1, MS_MAX);
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    send_evt(EVT_BOOT, 1'b1, 1'b0);
    send_evt(EVT_BOOT, 1'b1, 1'b1);
    send_ticks(5, 1'b1, 2);
    send_evt(EVT_BOOT, 1'b1, 1'b1);
    send_ticks(20, 1'b1, 0);
    send_ticks(1, 1'b0, 0);
    settle();
  endtask

  // One boot sequence with random content; most of them go for the update
  task automatic run_session();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_evt(EVT_BOOT, 1'b1, 1'b1);
      n = span(timing.hold_ms, 60);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
      send_ticks(n, 1'b1, 30);
      send_ticks($urandom_range(0, span(timing.release_ms, 60)), 1'b1, 0);
      send_ticks($urandom_range(1, span(timing.blink_ms, 20) + 2), 1'b0, 0);
      send_ticks($urandom_range(0, 3), 1'b0, 2);
    end else if (pick < 75) begin
      send_evt(EVT_BOOT, 1'b1, 1'b1);
      send_ticks($urandom_range(0, span(timing.arm_flash_ms, 60) + 3), 1'b1, 2);
    end else if (pick < 87) begin
      if ($urandom_range(0, 1) == 0) send_evt(EVT_BOOT, 1'b1, 1'b0);
      else send_evt(EVT_BOOT, 1'b0, 1'($urandom_range(0, 1)));
    end else begin
      // Noise: any mix of fields
      repeat ($urandom_range(1, 8))
        send_evt(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  // Random sessions under changing timing: all ones first, then mostly
  // small values, sometimes a register at the top of its range.
  task automatic test_random_sessions();
    int unsigned stop_at;
    int unsigned sessions;
    ms_t         hold;
    ms_t         rel;
    ms_t         blink;
    ms_t         flash;
    stop_at  = items_sent + RANDOM_ITEMS;
    sessions = 0;
    program_timing(16'd1, 16'd1, 16'd1, 16'd1);
    while (items_sent < stop_at) begin
      if (sessions != 0 && sessions % SESSIONS_PER_CFG == 0) begin
        settle();
        hold  = ms_t'($urandom_range(1, 12));
        rel   = ms_t'($urandom_range(1, 20));
        blink = ms_t'($urandom_range(1, 6));
        flash = ms_t'($urandom_range(1, 8));
        case ($urandom_range(0, 9))
          0: hold  = MS_MAX;
          1: rel   = MS_MAX;
          2: blink = MS_MAX;
          3: flash = MS_MAX;
          4: rel   = ms_t'($urandom_range(1, 65535));
          default: ;
        endcase
        program_timing(hold, rel, blink, flash);
      end
      // Leave some sessions free of idling on either side
      src_gaps    = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      run_session();
      sessions++;
    end
    settle();
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_HOLD;
    cfg_wdata    <= '0;
    evt_ch.valid <= 1'b0;
    evt_ch.data  <= '0;
    src_gaps       = 1'b0;
    sink_stalls    = 1'b0;
    items_sent     = 0;
    results_seen   = 0;
    mismatch_count = 0;
    // Mirror the reset values of the timing and the guard
    timing.hold_ms      = HOLD_RST;
    timing.release_ms   = RELEASE_RST;
    timing.blink_ms     = BLINK_RST;
    timing.arm_flash_ms = ARM_FLASH_RST;
    guard_phase   = PH_IDLE;
    guard_elapsed = '0;
    guard_blinks  = '0;
    guard_led     = 1'b0;
    guard_armed   = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_timing();
    test_directed_paths();
    test_full_scale_hold();
    test_random_sessions();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
